[rtl/slp_pkg.sv]
// slp_pkg: request, result and table entry types, operation and status codes
// shared by all files of the section latency profiler but slp_ram; depends on nothing
`default_nettype none

package slp_pkg;

  localparam int ID_FIELD_BITS = 16;   // width of the section_id field
  localparam int SLOT_BITS_MAX = 8;    // enough for the largest table

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BEGIN_OPEN = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_END_CLOSED = 3'd4;

  localparam logic [63:0] TICKS_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] CALLS_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]               operation;
    logic [ID_FIELD_BITS-1:0] section_id;
    logic [63:0]              timestamp;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [63:0] elapsed_ticks;
    logic [63:0] total_ticks;
    logic [31:0] call_count;
    logic [63:0] min_ticks;
    logic [63:0] max_ticks;
  } res_t;

  // statistics of one table slot, one word of the stats memory
  typedef struct packed {
    logic [63:0] start_ticks;
    logic [63:0] total_ticks;
    logic [31:0] calls;
    logic [63:0] min_ticks;
    logic [63:0] max_ticks;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{
    start_ticks: 64'd0,
    total_ticks: 64'd0,
    calls:       32'd0,
    min_ticks:   TICKS_ALL_ONES,
    max_ticks:   64'd0
  };

  // outcome of one key search
  typedef struct packed {
    logic                     done;
    logic                     found;
    logic [SLOT_BITS_MAX-1:0] slot;
  } search_res_t;

endpackage

`default_nettype wire

[rtl/slp_ram.sv]
// slp_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module slp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/slp_search.sv]
// slp_search: key memory and a scan that compares one stored key a cycle
// depends on slp_pkg and slp_ram
`default_nettype none

module slp_search #(
  parameter int ENTRIES = 16,
  parameter int KEYW    = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          start,
  input  wire logic [KEYW-1:0]                               key,
  input  wire logic [$clog2(ENTRIES+1)-1:0]                  used,
  input  wire logic                                          key_we,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] key_waddr,
  input  wire logic [KEYW-1:0]                               key_wdata,
  output slp_pkg::search_res_t                               sres
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);

  logic            busy;
  logic [CNTW-1:0] idx;
  logic            chk;
  logic [IDXW-1:0] chk_idx;
  logic [KEYW-1:0] key_rd;
  logic            issue;
  logic            hit;
  logic            miss;
  logic [IDXW+slp_pkg::SLOT_BITS_MAX-1:0] slot_wide;

  assign issue = busy && (idx < used);
  assign hit   = busy && chk && (key_rd == key);
  assign miss  = busy && !chk && !(idx < used);

  slp_ram #(
    .WIDTH (KEYW),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (issue),
    .raddr (idx[IDXW-1:0]),
    .rdata (key_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      chk  <= 1'b0;
      idx  <= '0;
    end else if (hit || miss) begin
      busy <= 1'b0;
      chk  <= 1'b0;
    end else begin
      chk <= issue;
      if (issue) begin
        chk_idx <= idx[IDXW-1:0];
        idx     <= idx + CNTW'(1);
      end
    end
  end

  // keys are unique in the table, so the first hit is the only one
  assign slot_wide  = {{slp_pkg::SLOT_BITS_MAX{1'b0}}, chk_idx};
  assign sres.done  = hit || miss;
  assign sres.found = hit;
  assign sres.slot  = slot_wide[slp_pkg::SLOT_BITS_MAX-1:0];

endmodule

`default_nettype wire

[rtl/slp_update.sv]
// slp_update: folds one elapsed time into the statistics of an entry
// depends on slp_pkg
`default_nettype none

module slp_update (
  input  wire slp_pkg::entry_t cur,
  input  wire logic [63:0]     elapsed,
  output slp_pkg::entry_t      nxt
);

  always_comb begin
    nxt             = cur;
    nxt.total_ticks = cur.total_ticks + elapsed;   // wraps
    if (cur.calls != slp_pkg::CALLS_MAX) begin
      nxt.calls = cur.calls + 32'd1;
    end
    if (elapsed < cur.min_ticks) begin
      nxt.min_ticks = elapsed;
    end
    if (elapsed > cur.max_ticks) begin
      nxt.max_ticks = elapsed;
    end
  end

endmodule

`default_nettype wire

[rtl/section_latency_profiler.sv]
// section_latency_profiler: top level, sequencer around the key search and stats memory
// depends on slp_pkg, slp_ram, slp_search and slp_update
//
// usage
//   request channel (req_valid, req_stall, req): begin, end or clear of a timed
//   section, taken at an edge with req_valid high and req_stall low
//   result channel (res_valid, res_stall, res): one result for every request,
//   in request order, held steady while res_stall is high
//   one request is worked on at a time; req_stall is high from the cycle after
//   acceptance until the result has been put into the output register
//   clear and unused codes: no search, the result goes straight to S_RESULT
//   begin and end: the key memory is scanned one slot a cycle, so the wait
//   grows with the slot of a found section, or with the entries in use for a
//   miss or a new slot; a found section passes S_READ and S_CALC, and a good
//   end also S_UPD, before S_RESULT; the scan sets the rate
//   while a result waits under res_stall the next request is still taken; the
//   block stalls only when a second result would need the output register
//   reset empties the table and drops any result not yet taken; key and stats
//   memories are not cleared, only slots below the fill count are ever read
`default_nettype none

module section_latency_profiler #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ID_BITS       = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire slp_pkg::req_t req,
  output logic              res_valid,
  input  wire logic         res_stall,
  output slp_pkg::res_t     res
);

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int KEYW = (ID_BITS < slp_pkg::ID_FIELD_BITS) ? ID_BITS
                                                           : slp_pkg::ID_FIELD_BITS;
  localparam int ENTW = $bits(slp_pkg::entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_CALC,
    S_UPD,
    S_RESULT
  } state_t;

  state_t                   state;
  logic                     go;
  logic [1:0]               op_q;
  logic [KEYW-1:0]          key_q;
  logic [63:0]              ts_q;
  logic [IDXW-1:0]          slot_q;
  logic [63:0]              elapsed_q;
  logic [CNTW-1:0]          used;
  logic [TABLE_ENTRIES-1:0] open_q;
  slp_pkg::res_t            pending;

  slp_pkg::search_res_t     sres;
  slp_pkg::entry_t          st_rd;
  slp_pkg::entry_t          st_upd;
  slp_pkg::entry_t          st_wdata;
  slp_pkg::entry_t          fresh;
  logic                     st_we;
  logic [IDXW-1:0]          st_waddr;
  logic                     full;
  logic [IDXW-1:0]          used_slot;
  logic                     alloc;

  // slot number as shown on the result, low four bits
  function automatic logic [3:0] slot_out(input logic [IDXW-1:0] s);
    logic [IDXW+3:0] w;
    w = {4'b0000, s};
    return w[3:0];
  endfunction

  function automatic slp_pkg::res_t make_res(input logic [2:0]      st,
                                             input logic [3:0]      idx,
                                             input logic [63:0]     el,
                                             input slp_pkg::entry_t e);
    slp_pkg::res_t r;
    r.status        = st;
    r.entry_index   = idx;
    r.elapsed_ticks = el;
    r.total_ticks   = e.total_ticks;
    r.call_count    = e.calls;
    r.min_ticks     = e.min_ticks;
    r.max_ticks     = e.max_ticks;
    return r;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign full      = (used == CNTW'(TABLE_ENTRIES));
  assign used_slot = used[IDXW-1:0];

  // a begin on an unknown id takes the next free slot
  assign alloc = (state == S_SEARCH) && sres.done && !sres.found &&
                 (op_q == slp_pkg::OP_BEGIN) && !full;

  always_comb begin
    fresh             = slp_pkg::EMPTY_ENTRY;
    fresh.start_ticks = ts_q;
  end

  // key memory and scan
  slp_search #(
    .ENTRIES (TABLE_ENTRIES),
    .KEYW    (KEYW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (go),
    .key       (key_q),
    .used      (used),
    .key_we    (alloc),
    .key_waddr (used_slot),
    .key_wdata (key_q),
    .sres      (sres)
  );

  // stats memory write side: new slot, start of a section, or end update
  always_comb begin
    st_we    = 1'b0;
    st_waddr = slot_q;
    st_wdata = st_rd;
    priority if (alloc) begin
      st_we    = 1'b1;
      st_waddr = used_slot;
      st_wdata = fresh;
    end else if ((state == S_CALC) && (op_q == slp_pkg::OP_BEGIN) && !open_q[slot_q]) begin
      st_we                = 1'b1;
      st_wdata.start_ticks = ts_q;
    end else if (state == S_UPD) begin
      st_we    = 1'b1;
      st_wdata = st_upd;
    end else begin
      st_we = 1'b0;
    end
  end

  slp_ram #(
    .WIDTH (ENTW),
    .DEPTH (TABLE_ENTRIES)
  ) u_stats_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (state == S_READ),
    .raddr (slot_q),
    .rdata (st_rd)
  );

  slp_update u_update (
    .cur     (st_rd),
    .elapsed (elapsed_q),
    .nxt     (st_upd)
  );

  // sequencer, table bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      res_valid <= 1'b0;
      used      <= '0;
      open_q    <= '0;
    end else begin
      // begin and end start a key search the cycle after acceptance
      go <= (state == S_IDLE) && req_valid &&
            ((req.operation == slp_pkg::OP_BEGIN) || (req.operation == slp_pkg::OP_END));
      // a taken result empties the register unless the next one moves in
      if (res_valid && !res_stall && (state != S_RESULT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q  <= req.operation;
            key_q <= req.section_id[KEYW-1:0];
            ts_q  <= req.timestamp;
            priority case (req.operation)
              slp_pkg::OP_BEGIN, slp_pkg::OP_END: begin
                state <= S_SEARCH;
              end
              slp_pkg::OP_CLEAR: begin
                used    <= '0;
                open_q  <= '0;
                pending <= make_res(slp_pkg::ST_OK, 4'd0, 64'd0, slp_pkg::EMPTY_ENTRY);
                state   <= S_RESULT;
              end
              default: begin
                // unused code, no table change
                pending <= make_res(slp_pkg::ST_OK, 4'd0, 64'd0, slp_pkg::EMPTY_ENTRY);
                state   <= S_RESULT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (sres.done) begin
            priority if (sres.found) begin
              slot_q <= sres.slot[IDXW-1:0];
              state  <= S_READ;
            end else if (alloc) begin
              used              <= used + CNTW'(1);
              open_q[used_slot] <= 1'b1;
              pending <= make_res(slp_pkg::ST_OK, slot_out(used_slot), 64'd0, fresh);
              state   <= S_RESULT;
            end else begin
              pending <= make_res((op_q == slp_pkg::OP_BEGIN) ? slp_pkg::ST_FULL
                                                                : slp_pkg::ST_NOT_FOUND,
                                  4'd0, 64'd0, slp_pkg::EMPTY_ENTRY);
              state   <= S_RESULT;
            end
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (op_q == slp_pkg::OP_BEGIN) begin
            if (open_q[slot_q]) begin
              pending <= make_res(slp_pkg::ST_BEGIN_OPEN, slot_out(slot_q), 64'd0, st_rd);
            end else begin
              open_q[slot_q] <= 1'b1;
              pending <= make_res(slp_pkg::ST_OK, slot_out(slot_q), 64'd0, st_rd);
            end
            state <= S_RESULT;
          end else if (!open_q[slot_q]) begin
            pending <= make_res(slp_pkg::ST_END_CLOSED, slot_out(slot_q), 64'd0, st_rd);
            state   <= S_RESULT;
          end else begin
            // elapsed modulo 2^64, folded in next cycle
            elapsed_q <= ts_q - st_rd.start_ticks;
            state     <= S_UPD;
          end
        end
        S_UPD: begin
          open_q[slot_q] <= 1'b0;
          pending <= make_res(slp_pkg::ST_OK, slot_out(slot_q), elapsed_q, st_upd);
          state   <= S_RESULT;
        end
        S_RESULT: begin
          // wait for the output register to be free
          if (!res_valid || !res_stall) begin
            res       <= pending;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/slp_checker.sv]
// slp_checker: port level checks of the section latency profiler, bound to the top
// depends on slp_pkg and section_latency_profiler
`default_nettype none

module slp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          res_valid,
  input wire logic          res_stall,
  input wire slp_pkg::res_t res
);

  // a waiting result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // one request at a time: stall follows every acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while a request is in progress");

  // failed operations carry no elapsed time
  a_fail_no_elapsed: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != slp_pkg::ST_OK) |-> (res.elapsed_ticks == 64'd0))
    else $error("elapsed time on a failed operation");

  // once a section has completed a call its minimum cannot exceed its maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.call_count != 32'd0) |-> (res.min_ticks <= res.max_ticks))
    else $error("minimum above maximum");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind section_latency_profiler slp_checker u_slp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

[tb/section_latency_profiler_tb.sv]
`timescale 1ns / 100ps
// section_latency_profiler_tb: self-checking bench for the section latency profiler,
// with a queued request driver, a random result stall and an in-bench table predictor
// depends on slp_pkg and section_latency_profiler
module section_latency_profiler_tb;

  localparam int TABLE_SIZE = 16;
  localparam int KEY_BITS = 16;
  localparam logic [15:0] KEY_MASK = 16'((1 << KEY_BITS) - 1);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 20;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  slp_pkg::req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  slp_pkg::res_t res;

  // request queue filled up front, and results still owed by the block
  slp_pkg::req_t pending_reqs[$];
  slp_pkg::res_t owed_results[$];
  int errors = 0;
  bit req_fire = 1'b0;
  bit req_calm = 1'b0;
  bit res_calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // predicted section table
  logic [15:0] slot_key[TABLE_SIZE];
  bit slot_open[TABLE_SIZE];
  logic [63:0] slot_start[TABLE_SIZE];
  logic [63:0] slot_total[TABLE_SIZE];
  logic [31:0] slot_calls[TABLE_SIZE];
  logic [63:0] slot_min[TABLE_SIZE];
  logic [63:0] slot_max[TABLE_SIZE];
  int slots_used = 0;

  section_latency_profiler #(
    .TABLE_ENTRIES(TABLE_SIZE),
    .ID_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] random_ticks();
    return {$urandom(), $urandom()};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result fields of a slot, or of an empty entry when no slot is involved
  function automatic slp_pkg::res_t slot_report(logic [2:0] status, int slot,
                                                logic [63:0] elapsed);
    slp_pkg::res_t o;
    o.status = status;
    o.elapsed_ticks = elapsed;
    if (slot < 0) begin
      o.entry_index = '0;
      o.total_ticks = '0;
      o.call_count = '0;
      o.min_ticks = slp_pkg::TICKS_ALL_ONES;
      o.max_ticks = '0;
    end else begin
      o.entry_index = slot[3:0];
      o.total_ticks = slot_total[slot];
      o.call_count = slot_calls[slot];
      o.min_ticks = slot_min[slot];
      o.max_ticks = slot_max[slot];
    end
    return o;
  endfunction

  // applies one accepted request to the predicted table and gives its result
  function automatic slp_pkg::res_t predict_section(slp_pkg::req_t r);
    logic [15:0] key;
    logic [63:0] span;
    int slot;
    int i;
    key = r.section_id & KEY_MASK;
    slot = -1;
    for (i = 0; i < slots_used; i++) begin
      if (slot < 0 && slot_key[i] == key) slot = i;
    end
    case (r.operation)
      slp_pkg::OP_BEGIN: begin
        if (slot < 0) begin
          if (slots_used >= TABLE_SIZE) return slot_report(slp_pkg::ST_FULL, -1, '0);
          slot = slots_used;
          slots_used++;
          slot_key[slot] = key;
          slot_open[slot] = 1'b0;
          slot_total[slot] = '0;
          slot_calls[slot] = '0;
          slot_min[slot] = slp_pkg::TICKS_ALL_ONES;
          slot_max[slot] = '0;
        end
        if (slot_open[slot]) return slot_report(slp_pkg::ST_BEGIN_OPEN, slot, '0);
        slot_open[slot] = 1'b1;
        slot_start[slot] = r.timestamp;
        return slot_report(slp_pkg::ST_OK, slot, '0);
      end
      slp_pkg::OP_END: begin
        if (slot < 0) return slot_report(slp_pkg::ST_NOT_FOUND, -1, '0);
        if (!slot_open[slot]) return slot_report(slp_pkg::ST_END_CLOSED, slot, '0);
        span = r.timestamp - slot_start[slot];
        slot_total[slot] = slot_total[slot] + span;
        if (slot_calls[slot] != slp_pkg::CALLS_MAX)
          slot_calls[slot] = slot_calls[slot] + 32'd1;
        if (span < slot_min[slot]) slot_min[slot] = span;
        if (span > slot_max[slot]) slot_max[slot] = span;
        slot_open[slot] = 1'b0;
        return slot_report(slp_pkg::ST_OK, slot, span);
      end
      slp_pkg::OP_CLEAR: begin
        for (i = 0; i < TABLE_SIZE; i++) slot_open[i] = 1'b0;
        slots_used = 0;
        return slot_report(slp_pkg::ST_OK, -1, '0);
      end
      default: return slot_report(slp_pkg::ST_OK, -1, '0);
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic queue_item(logic [1:0] op, logic [15:0] id, logic [63:0] ts);
    slp_pkg::req_t item;
    item.operation = op;
    item.section_id = id;
    item.timestamp = ts;
    pending_reqs.push_back(item);
  endtask

  // request driver: payload held while stalled, random gap after each acceptance
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if ($urandom_range(0, 199) == 0) req_calm = !req_calm;
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        gap_left = req_calm ? 0 : pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result stall: bursts of random length, with calm stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 499) == 0) res_calm = !res_calm;
    if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if (!res_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: predict on request acceptance, check on result acceptance
  always @(posedge clk) begin
    slp_pkg::res_t want;
    if (rst) begin
      slots_used = 0;
      for (int i = 0; i < TABLE_SIZE; i++) slot_open[i] = 1'b0;
      req_fire = 1'b0;
    end else begin
      req_fire = req_valid && !req_stall;
      if (req_fire) owed_results.push_back(predict_section(req));
      if (res_valid && !res_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t ns: result with none expected, actual %h", $time, res);
        end else begin
          want = owed_results.pop_front();
          check_field("status", 64'(want.status), 64'(res.status));
          check_field("entry_index", 64'(want.entry_index), 64'(res.entry_index));
          check_field("elapsed_ticks", want.elapsed_ticks, res.elapsed_ticks);
          check_field("total_ticks", want.total_ticks, res.total_ticks);
          check_field("call_count", 64'(want.call_count), 64'(res.call_count));
          check_field("min_ticks", want.min_ticks, res.min_ticks);
          check_field("max_ticks", want.max_ticks, res.max_ticks);
        end
      end
    end
  end

  initial begin
    logic [15:0] id_pool[POOL_SIZE];
    bit pool_open[POOL_SIZE];
    logic [63:0] now;
    int n;
    int k;
    int roll;
    int pick;

    // directed: unknown id, reopen, closed end, extreme ids and timestamps, wrap
    queue_item(slp_pkg::OP_END, 16'h1234, 64'd7);
    queue_item(slp_pkg::OP_BEGIN, 16'h0000, 64'd0);
    queue_item(slp_pkg::OP_BEGIN, 16'h0000, 64'd99);
    queue_item(slp_pkg::OP_END, 16'h0000, slp_pkg::TICKS_ALL_ONES);
    queue_item(slp_pkg::OP_END, 16'h0000, 64'd5);
    queue_item(slp_pkg::OP_BEGIN, 16'hFFFF, slp_pkg::TICKS_ALL_ONES);
    queue_item(slp_pkg::OP_END, 16'hFFFF, 64'd5);
    queue_item(OP_UNUSED, 16'hFFFF, slp_pkg::TICKS_ALL_ONES);
    queue_item(slp_pkg::OP_CLEAR, 16'hA5A5, 64'd1);
    // fill every slot, then a begin on a full table and an end on the refused id
    for (k = 0; k < TABLE_SIZE; k++)
      queue_item(slp_pkg::OP_BEGIN, 16'(16'h8000 + k), random_ticks());
    queue_item(slp_pkg::OP_BEGIN, 16'h4321, 64'd3);
    queue_item(slp_pkg::OP_END, 16'h4321, 64'd4);

    // random: begin/end pairs on a small pool of ids, plus clears and noise
    for (k = 0; k < POOL_SIZE; k++) begin
      id_pool[k] = 16'($urandom());
      pool_open[k] = 1'b0;
    end
    now = random_ticks();
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 49) == 0) now = random_ticks();
      else now = now + 64'($urandom_range(1, 400));
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        queue_item(slp_pkg::OP_CLEAR, 16'($urandom()), random_ticks());
        for (k = 0; k < POOL_SIZE; k++) begin
          id_pool[k] = 16'($urandom());
          pool_open[k] = 1'b0;
        end
      end else if (roll < 4) begin
        queue_item(OP_UNUSED, 16'($urandom()), random_ticks());
      end else if (roll < 9) begin
        queue_item((roll < 6) ? slp_pkg::OP_BEGIN : slp_pkg::OP_END, 16'($urandom()),
                   random_ticks());
      end else begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        if (pool_open[pick]) begin
          if ($urandom_range(0, 3) != 0) begin
            queue_item(slp_pkg::OP_END, id_pool[pick], now);
            pool_open[pick] = 1'b0;
          end else begin
            queue_item(slp_pkg::OP_BEGIN, id_pool[pick], now);
          end
        end else if ($urandom_range(0, 99) < 85) begin
          queue_item(slp_pkg::OP_BEGIN, id_pool[pick], now);
          pool_open[pick] = 1'b1;
        end else begin
          queue_item(slp_pkg::OP_END, id_pool[pick], now);
        end
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
